/* hw/rtl/radix_digit_converter_defines.svh */
// Assertion macros used by the radix digit converter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RDC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rdc: same-cycle property violated");

// Next-cycle implication, disabled while in reset.
`define RDC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rdc: next-cycle property violated");

`endif

/* hw/rtl/rdc_pkg.sv */
// Package for the radix digit converter: widths, limits, FSM state type
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package rdc_pkg;

    localparam int WORD_W      = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int STORE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] RADIX_RESET = WORD_W'(10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_STORE,
        ST_READ,
        ST_EMIT,
        ST_ERROR
    } rdc_state_t;

    typedef struct packed {
        logic load;        // take a new value, clear digit count
        logic div_start;   // clear remainder and bit counter
        logic div_step;    // one restoring division step
        logic store_rem;   // write remainder as next digit
        logic store_zero;  // write a single zero digit
        logic mem_read;    // read digit store at emit index
        logic idx_dec;     // step emit index towards the least significant digit
        logic out_digit;   // load output register with read digit
        logic out_err;     // load output register with the overflow result
    } rdc_cmd_t;

    typedef struct packed {
        logic radix_lt2;
        logic quot_zero;
        logic div_last;
        logic count_full;
        logic idx_zero;
        logic out_free;
    } rdc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/rdc_ctrl.sv */
// Controller FSM of the radix digit converter: sequences division, digit
// storage and emission. Depends on rdc_pkg.
`default_nettype none

module rdc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rdc_pkg::rdc_status_t status,
    output rdc_pkg::rdc_cmd_t        cmd
);
    import rdc_pkg::*;

    rdc_state_t state_reg;
    rdc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (status.radix_lt2) begin
                    state_next = status.quot_zero ? ST_READ : ST_ERROR;
                end else if (status.count_full) begin
                    state_next = ST_ERROR;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                state_next = status.quot_zero ? ST_READ : ST_CHECK;
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = status.idx_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_ERROR: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CHECK: begin
                priority if (status.radix_lt2) begin
                    cmd.store_zero = status.quot_zero;
                end else if (!status.count_full) begin
                    cmd.div_start = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_STORE: begin
                cmd.store_rem = 1'b1;
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
            end
            ST_EMIT: begin
                cmd.out_digit = status.out_free;
                cmd.idx_dec   = status.out_free && !status.idx_zero;
            end
            ST_ERROR: begin
                cmd.out_err = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/rdc_datapath.sv */
// Datapath of the radix digit converter: radix register, restoring divider,
// digit store memory and output register. Depends on rdc_pkg and the defines header.
`default_nettype none
`include "radix_digit_converter_defines.svh"

module rdc_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr,
    input  wire logic [rdc_pkg::WORD_W-1:0]  cfg_radix,
    input  wire logic [rdc_pkg::WORD_W-1:0]  s_value,
    input  wire rdc_pkg::rdc_cmd_t           cmd,
    output rdc_pkg::rdc_status_t             status,
    input  wire logic                        m_ready,
    output logic                             m_valid,
    output logic [rdc_pkg::WORD_W-1:0]       m_digit,
    output logic                             m_last_digit,
    output logic                             m_too_many_digits
);
    import rdc_pkg::*;

    logic [WORD_W-1:0]    radix_reg;
    logic [WORD_W-1:0]    quot_reg;
    logic [WORD_W-1:0]    quot_next;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    rem_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [CNT_W-1:0]     ndig_reg;
    logic [CNT_W-1:0]     ndig_next;
    logic [ADDR_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]    idx_next;

    logic [WORD_W-1:0]    store_mem [STORE_DEPTH];
    logic [WORD_W-1:0]    rd_data_reg;

    logic                 valid_reg;
    logic [WORD_W-1:0]    digit_reg;
    logic                 last_reg;
    logic                 err_reg;

    logic [WORD_W:0]      trial;      // partial remainder with next dividend bit
    logic [WORD_W+1:0]    diff;
    logic                 fits;

    // Restoring division step: shift in the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, quot_reg[WORD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, radix_reg};
    assign fits  = !diff[WORD_W+1];

    always_comb begin
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        if (cmd.load) begin
            quot_next = s_value;
        end else if (cmd.div_start) begin
            rem_next     = '0;
            bit_cnt_next = '0;
        end else if (cmd.div_step) begin
            quot_next    = {quot_reg[WORD_W-2:0], fits};
            rem_next     = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        end
    end

    always_comb begin
        ndig_next = ndig_reg;
        idx_next  = idx_reg;
        if (cmd.load) begin
            ndig_next = '0;
        end else if (cmd.store_rem || cmd.store_zero) begin
            ndig_next = ndig_reg + CNT_W'(1);
            idx_next  = ndig_reg[ADDR_W-1:0];
        end else if (cmd.idx_dec) begin
            idx_next  = idx_reg - ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg   <= RADIX_RESET;
            ndig_reg    <= '0;
            quot_reg    <= '0;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            idx_reg     <= '0;
        end else begin
            if (cfg_wr) begin
                radix_reg <= cfg_radix;
            end
            ndig_reg    <= ndig_next;
            quot_reg    <= quot_next;
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_next;
            idx_reg     <= idx_next;
        end
    end

    // Digit store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.store_rem || cmd.store_zero) begin
            store_mem[ndig_reg[ADDR_W-1:0]] <= cmd.store_zero ? '0 : rem_reg;
        end
        if (cmd.mem_read) begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_digit || cmd.out_err) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_digit) begin
            digit_reg <= rd_data_reg;
            last_reg  <= (idx_reg == '0);
            err_reg   <= 1'b0;
        end else if (cmd.out_err) begin
            digit_reg <= '0;
            last_reg  <= 1'b1;
            err_reg   <= 1'b1;
        end
    end

    assign status.radix_lt2  = (radix_reg[WORD_W-1:1] == '0);
    assign status.quot_zero  = (quot_reg == '0);
    assign status.div_last   = (bit_cnt_reg == BIT_CNT_W'(WORD_W - 1));
    assign status.count_full = (ndig_reg == CNT_W'(MAX_DIGITS));
    assign status.idx_zero   = (idx_reg == '0);
    assign status.out_free   = !valid_reg || m_ready;

    assign m_valid           = valid_reg;
    assign m_digit           = digit_reg;
    assign m_last_digit      = last_reg;
    assign m_too_many_digits = err_reg;

    `RDC_ASSERT_IMP(a_err_shape, aclk, aresetn, valid_reg && err_reg, (digit_reg == '0) && last_reg)
    `RDC_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, ndig_reg <= CNT_W'(MAX_DIGITS))
    `RDC_ASSERT_IMP(a_rem_below_radix, aclk, aresetn, cmd.store_rem, rem_reg < radix_reg)

endmodule

`default_nettype wire

/* hw/rtl/radix_digit_converter.sv */
// Radix digit converter: splits a 32-bit unsigned value into digits of a
// programmable base. Each digit takes a check state, a restoring division
// in the datapath's divider at one quotient bit per cycle, and a store state,
// and is then read back from the digit store and emitted through a read
// state and an emit state, which waits until the output register is free.
// One item is worked on at a time. Digits come out most significant first with
// m_last_digit on the final one; a value needing more digits than the store
// holds (or a non-zero value with radix below two) gives one result with
// m_too_many_digits set and digit zero. The radix (reset 10) is written through
// the cfg channel only while the block is idle: the user is bound to keep to
// this, as the block itself does not enforce it.
// Depends on rdc_pkg, rdc_ctrl and rdc_datapath.
`default_nettype none

module radix_digit_converter (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rdc_pkg::WORD_W-1:0]  cfg_radix,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [rdc_pkg::WORD_W-1:0]  s_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [rdc_pkg::WORD_W-1:0]       m_digit,
    output logic                             m_last_digit,
    output logic                             m_too_many_digits
);
    import rdc_pkg::*;

    rdc_cmd_t    cmd;
    rdc_status_t status;

    assign cfg_ready = 1'b1;

    rdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rdc_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr            (cfg_valid && cfg_ready),
        .cfg_radix         (cfg_radix),
        .s_value           (s_value),
        .cmd               (cmd),
        .status            (status),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_digit           (m_digit),
        .m_last_digit      (m_last_digit),
        .m_too_many_digits (m_too_many_digits)
    );

endmodule

`default_nettype wire

/* tb/radix_digit_converter_test.sv */
// Self-checking testbench for radix_digit_converter: random and directed values are
// converted under a range of radix settings and every digit is checked in order.
// Depends on rdc_pkg and the radix_digit_converter RTL only.

module radix_digit_converter_test;

    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [rdc_pkg::WORD_W-1:0] digit;
        logic                       last_digit;
        logic                       too_many;
    } digit_result_t;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [rdc_pkg::WORD_W-1:0] cfg_radix = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [rdc_pkg::WORD_W-1:0] s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [rdc_pkg::WORD_W-1:0] m_digit;
    logic                       m_last_digit;
    logic                       m_too_many_digits;

    logic [rdc_pkg::WORD_W-1:0] pending_values [$];
    digit_result_t              expected_digits [$];
    logic [rdc_pkg::WORD_W-1:0] radix_now = rdc_pkg::RADIX_RESET;
    int unsigned                values_queued = 0;
    int unsigned                values_taken = 0;
    int unsigned                failures = 0;
    int unsigned                cycle_count = 0;
    bit                         steady_flow = 1'b0;

    radix_digit_converter dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_radix         (cfg_radix),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_value           (s_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_digit           (m_digit),
        .m_last_digit      (m_last_digit),
        .m_too_many_digits (m_too_many_digits)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Digits of one value, most significant first; radix below two never shrinks
    // the quotient, so any non-zero value overflows the store.
    function automatic void predict_digits(input logic [rdc_pkg::WORD_W-1:0] value,
                                           input logic [rdc_pkg::WORD_W-1:0] base);
        logic [rdc_pkg::WORD_W-1:0] quotient;
        logic [rdc_pkg::WORD_W-1:0] remainders [$];
        digit_result_t              res;
        res = '0;
        res.last_digit = 1'b1;
        if (base < 2) begin
            res.too_many = (value != 0);
            expected_digits.push_back(res);
        end else begin
            quotient = value;
            do begin
                remainders.push_front(quotient % base);
                quotient = quotient / base;
            end while (quotient != 0);
            if (remainders.size() > rdc_pkg::MAX_DIGITS) begin
                res.too_many = 1'b1;
                expected_digits.push_back(res);
            end else begin
                while (remainders.size() != 0) begin
                    res.digit = remainders.pop_front();
                    res.last_digit = (remainders.size() == 0);
                    expected_digits.push_back(res);
                end
            end
        end
    endfunction

    // Mix of full-range values, small ones and values on digit-count boundaries.
    function automatic logic [rdc_pkg::WORD_W-1:0] pick_value(
            input logic [rdc_pkg::WORD_W-1:0] base);
        int unsigned sel;
        int unsigned steps;
        logic [63:0] power;
        sel = $urandom_range(9);
        if (sel < 4) begin
            return $urandom();
        end else if (sel < 6) begin
            return $urandom_range(1000);
        end else if (sel < 8) begin
            power = 64'd1;
            steps = $urandom_range(32);
            repeat (steps) begin
                if (power * base <= 64'hFFFF_FFFF) power = power * base;
            end
            return rdc_pkg::WORD_W'(power - 64'($urandom_range(1)));
        end else if (sel == 8) begin
            return $urandom_range(1);
        end else begin
            return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000 | $urandom_range(15);
        end
    endfunction

    task automatic queue_value(input logic [rdc_pkg::WORD_W-1:0] value);
        pending_values.push_back(value);
        values_queued++;
    endtask

    task automatic wait_idle();
        while (values_taken != values_queued || expected_digits.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) queue_value(pick_value(radix_now));
        wait_idle();
    endtask

    task automatic write_radix(input logic [rdc_pkg::WORD_W-1:0] base);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_radix <= base;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        radix_now = base;
        @(negedge aclk);
    endtask

    // Source side: predicts on each accepted transaction, then presents the next value.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_digits(s_value, radix_now);
                values_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_values.size() != 0 && (steady_flow || $urandom_range(99) >= 33)) begin
                    s_valid <= 1'b1;
                    s_value <= pending_values.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: checks each accepted digit against the oldest expectation.
    always @(posedge aclk) begin
        digit_result_t got;
        digit_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{digit: m_digit, last_digit: m_last_digit, too_many: m_too_many_digits};
                if (expected_digits.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected digit %0h last %0b too_many %0b",
                                 got.digit, got.last_digit, got.too_many);
                end else begin
                    want = expected_digits.pop_front();
                    if (got.digit !== want.digit || got.last_digit !== want.last_digit ||
                        got.too_many !== want.too_many) begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: expected %0h/%0b/%0b got %0h/%0b/%0b",
                                     want.digit, want.last_digit, want.too_many,
                                     got.digit, got.last_digit, got.too_many);
                    end
                end
            end
            m_ready <= steady_flow || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset radix of ten: zero, digit-count boundaries, full range
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(32'd9);
        queue_value(32'd10);
        queue_value(32'd1000000000);
        queue_value(32'h8000_0000);
        queue_value(32'hFFFF_FFFF);
        run_random(60);

        // binary: a full 32-digit conversion
        write_radix(32'd2);
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(32'h8000_0000);
        queue_value(32'hFFFF_FFFF);
        run_random(30);

        write_radix(32'd16);
        steady_flow = 1'b1;
        run_random(60);
        steady_flow = 1'b0;

        // largest radix: single digit up to its maximum, then two digits
        write_radix(32'hFFFF_FFFF);
        queue_value(32'hFFFF_FFFE);
        queue_value(32'hFFFF_FFFF);
        run_random(40);

        // radix below two: only zero converts, anything else overflows the store
        write_radix(32'd0);
        queue_value(32'd0);
        queue_value(32'd5);
        run_random(25);

        write_radix(32'd1);
        queue_value(32'd0);
        queue_value(32'hFFFF_FFFF);
        run_random(25);

        write_radix(32'd3);
        run_random(40);

        write_radix(32'h8000_0000);
        run_random(30);

        repeat (5) begin
            write_radix($urandom_range(3) == 0 ? $urandom() : $urandom_range(40, 2));
            run_random(30);
        end

        repeat (50) @(posedge aclk);
        if (failures == 0 && expected_digits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
